FILE: sv/pls_pkg.sv
// Package for the point light Lambert shading block.
// Holds payload and pipeline stage types, constants and the per-cell step functions.
// No dependencies.
package pls_pkg;

  localparam int LATENCY = 60;
  localparam int ROOT_CELLS = 32;
  localparam int COS_CELLS = 20;
  localparam logic [28:0] INV_4PI = 29'h145F306E;
  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    CFG_POS_X,
    CFG_POS_Y,
    CFG_POS_Z,
    CFG_RED,
    CFG_GREEN,
    CFG_BLUE,
    CFG_POWER
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [15:0] albedo_red;
    logic [15:0] albedo_green;
    logic [15:0] albedo_blue;
    logic [31:0] diffuse_in_red;
    logic [31:0] diffuse_in_green;
    logic [31:0] diffuse_in_blue;
  } pls_in_t;

  typedef struct packed {
    logic [31:0] illum_red;
    logic [31:0] illum_green;
    logic [31:0] illum_blue;
    logic [31:0] diffuse_out_red;
    logic [31:0] diffuse_out_green;
    logic [31:0] diffuse_out_blue;
    logic facing;
    logic zero_distance;
  } pls_out_t;

  typedef struct packed {
    logic [34:0] rem;
    logic [31:0] low;
    logic [31:0] quo;
    logic [33:0] den;
  } div_lane_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [63:0] src;
    logic [31:0] root;
  } root_lane_t;

  typedef struct packed {
    logic valid;
    logic zero;
    logic facing;
    logic [2:0] sat;
    logic [49:0] cdvd;
    logic [2:0][31:0] dif;
    logic [2:0][15:0] alb;
  } root_ctx_t;

  typedef struct packed {
    root_ctx_t ctx;
    root_lane_t rt;
    div_lane_t [2:0] il;
  } root_stage_t;

  typedef struct packed {
    logic valid;
    logic zero;
    logic facing;
    logic [2:0][31:0] dif;
    logic [2:0][15:0] alb;
    logic [2:0][31:0] il;
  } cos_ctx_t;

  typedef struct packed {
    cos_ctx_t ctx;
    div_lane_t cd;
  } cos_stage_t;

  function automatic div_lane_t div_step(div_lane_t l);
    div_lane_t o;
    logic [34:0] r2;
    logic [34:0] dd;
    o = l;
    r2 = {l.rem[33:0], l.low[31]};
    dd = {1'b0, l.den};
    o.low = {l.low[30:0], 1'b0};
    if (r2 >= dd) begin
      o.rem = r2 - dd;
      o.quo = {l.quo[30:0], 1'b1};
    end else begin
      o.rem = r2;
      o.quo = {l.quo[30:0], 1'b0};
    end
    return o;
  endfunction

  function automatic root_lane_t root_step(root_lane_t l);
    root_lane_t o;
    logic [33:0] r2;
    logic [33:0] t;
    o = l;
    r2 = {l.rem[31:0], l.src[63:62]};
    t = {l.root, 2'b01};
    o.src = {l.src[61:0], 2'b00};
    if (r2 >= t) begin
      o.rem = r2 - t;
      o.root = {l.root[30:0], 1'b1};
    end else begin
      o.rem = r2;
      o.root = {l.root[30:0], 1'b0};
    end
    return o;
  endfunction

endpackage

FILE: sv/point_light_lambert_shade.sv
// Top level of the point light Lambert shading block.
// Front pipeline, root/divide cell chain, cosine cell chain and output stages.
// Uses pls_pkg, pls_root_cell and pls_cos_cell.
//
// Usage:
//   Configuration: cfg_we writes cfg_wdata to register cfg_idx (light position,
//   color, power); unknown indexes are ignored. Write only while no item is
//   in flight.
//   Input: a transaction is taken at each edge with start high and busy low.
//   busy stays low, so one hit point can be issued every cycle.
//   Output: out_valid is high for one cycle carrying out_data, one result per
//   transaction, in order.
//   Throughput is one transaction per cycle: 32 square root / divide cells
//   and 20 cosine divide cells each retire one bit per cycle, fully pipelined.
//   The receiver cannot stall; results must be taken when shown.
//   Reset (rst_n low, synchronous) drops all transactions in flight and
//   restores the light registers to position 0, white color, power 1.0.
module point_light_lambert_shade import pls_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  pls_in_t     in_data,
  output logic        out_valid,
  output pls_out_t    out_data
);

  logic signed [2:0][31:0] lpos_r;
  logic [2:0][15:0] lcol_r;
  logic [31:0] lpow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lpos_r <= '0;
      lcol_r <= {3{16'hFFFF}};
      lpow_r <= 32'h0001_0000;
    end else if (cfg_we) begin
      case (cfg_idx_e'(cfg_idx))
        CFG_POS_X: lpos_r[0] <= cfg_wdata;
        CFG_POS_Y: lpos_r[1] <= cfg_wdata;
        CFG_POS_Z: lpos_r[2] <= cfg_wdata;
        CFG_RED:   lcol_r[0] <= cfg_wdata[15:0];
        CFG_GREEN: lcol_r[1] <= cfg_wdata[15:0];
        CFG_BLUE:  lcol_r[2] <= cfg_wdata[15:0];
        CFG_POWER: lpow_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic    s_valid_r;
  pls_in_t s_in_r;

  always_ff @(posedge clk) begin
    s_in_r <= in_data;
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else begin
      s_valid_r <= start && !busy;
    end
  end

  logic [2:0][31:0] s_hit;
  logic [2:0][15:0] s_nrm;
  logic [2:0][15:0] s_alb;
  logic [2:0][31:0] s_dif;

  assign s_hit = {s_in_r.hit_z, s_in_r.hit_y, s_in_r.hit_x};
  assign s_nrm = {s_in_r.normal_z, s_in_r.normal_y, s_in_r.normal_x};
  assign s_alb = {s_in_r.albedo_blue, s_in_r.albedo_green, s_in_r.albedo_red};
  assign s_dif = {s_in_r.diffuse_in_blue, s_in_r.diffuse_in_green, s_in_r.diffuse_in_red};

  logic [2:0][32:0] a_d;
  logic [2:0][31:0] a_mag_nxt;
  logic [2:0][47:0] a_prod;
  logic [31:0] a_m;
  logic [4:0]  a_sh_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_d[i] = {lpos_r[i][31], lpos_r[i]} - {s_hit[i][31], s_hit[i]};
      a_mag_nxt[i] = a_d[i][32] ? 32'(-a_d[i]) : a_d[i][31:0];
      a_prod[i] = 48'(lcol_r[i]) * 48'(lpow_r);
    end
    a_m = a_mag_nxt[0];
    if (a_mag_nxt[1] > a_m) begin
      a_m = a_mag_nxt[1];
    end
    if (a_mag_nxt[2] > a_m) begin
      a_m = a_mag_nxt[2];
    end
    a_sh_nxt = '0;
    for (int k = 0; k < 31; k++) begin
      if (a_m[k]) begin
        a_sh_nxt = 5'(30 - k);
      end
    end
  end

  logic a_valid_r, a_shr_r, a_zero_r;
  logic [4:0] a_sh_r;
  logic [2:0] a_neg_r;
  logic [2:0][31:0] a_mag_r, a_pc_r, a_dif_r;
  logic [2:0][15:0] a_nrm_r, a_alb_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      a_neg_r[i] <= a_d[i][32];
      a_pc_r[i] <= a_prod[i][47:16];
    end
    a_mag_r <= a_mag_nxt;
    a_shr_r <= a_m[31];
    a_zero_r <= (a_m == '0);
    a_sh_r <= a_sh_nxt;
    a_nrm_r <= s_nrm;
    a_alb_r <= s_alb;
    a_dif_r <= s_dif;
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= s_valid_r;
    end
  end

  logic [2:0][31:0] b_shl;
  logic [2:0][30:0] b_a_nxt;
  logic [2:0][60:0] b_pk_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      b_shl[i] = a_mag_r[i] << a_sh_r;
      b_a_nxt[i] = a_shr_r ? a_mag_r[i][31:1] : b_shl[i][30:0];
      b_pk_nxt[i] = 61'(a_pc_r[i]) * 61'(INV_4PI);
    end
  end

  logic b_valid_r, b_shr_r, b_zero_r;
  logic [4:0] b_sh_r;
  logic [2:0] b_neg_r;
  logic [2:0][30:0] b_a_r;
  logic [2:0][60:0] b_pk_r;
  logic [2:0][15:0] b_nrm_r, b_alb_r;
  logic [2:0][31:0] b_dif_r;

  always_ff @(posedge clk) begin
    b_a_r <= b_a_nxt;
    b_pk_r <= b_pk_nxt;
    b_neg_r <= a_neg_r;
    b_shr_r <= a_shr_r;
    b_sh_r <= a_sh_r;
    b_zero_r <= a_zero_r;
    b_nrm_r <= a_nrm_r;
    b_alb_r <= a_alb_r;
    b_dif_r <= a_dif_r;
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
    end
  end

  logic signed [31:0] c_e [3];
  logic [2:0][61:0] c_sq_nxt;
  logic [2:0][47:0] c_ne_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_e[i] = b_neg_r[i] ? 32'(-{1'b0, b_a_r[i]}) : {1'b0, b_a_r[i]};
      c_sq_nxt[i] = 62'(b_a_r[i]) * 62'(b_a_r[i]);
      c_ne_nxt[i] = 48'($signed(b_nrm_r[i])) * 48'(c_e[i]);
    end
  end

  logic c_valid_r, c_shr_r, c_zero_r;
  logic [4:0] c_sh_r;
  logic [2:0][61:0] c_sq_r;
  logic [2:0][47:0] c_ne_r;
  logic [2:0][60:0] c_pk_r;
  logic [2:0][15:0] c_alb_r;
  logic [2:0][31:0] c_dif_r;

  always_ff @(posedge clk) begin
    c_sq_r <= c_sq_nxt;
    c_ne_r <= c_ne_nxt;
    c_pk_r <= b_pk_r;
    c_shr_r <= b_shr_r;
    c_sh_r <= b_sh_r;
    c_zero_r <= b_zero_r;
    c_alb_r <= b_alb_r;
    c_dif_r <= b_dif_r;
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else begin
      c_valid_r <= b_valid_r;
    end
  end

  logic [63:0] d_e_nxt;
  logic signed [49:0] d_dot_nxt;
  logic [2:0][90:0] d_x_nxt;
  logic [5:0] d_sh2;

  always_comb begin
    d_e_nxt = 64'(c_sq_r[0]) + 64'(c_sq_r[1]) + 64'(c_sq_r[2]);
    d_dot_nxt = 50'($signed(c_ne_r[0])) + 50'($signed(c_ne_r[1]))
              + 50'($signed(c_ne_r[2]));
    d_sh2 = {c_sh_r, 1'b0};
    for (int i = 0; i < 3; i++) begin
      if (c_shr_r) begin
        d_x_nxt[i] = 91'(c_pk_r[i] >> 32);
      end else if (d_sh2 >= 6'd30) begin
        d_x_nxt[i] = 91'(c_pk_r[i]) << (d_sh2 - 6'd30);
      end else begin
        d_x_nxt[i] = 91'(c_pk_r[i]) >> (6'd30 - d_sh2);
      end
    end
  end

  logic d_valid_r, d_zero_r;
  logic [63:0] d_e_r;
  logic signed [49:0] d_dot_r;
  logic [2:0][90:0] d_x_r;
  logic [2:0][15:0] d_alb_r;
  logic [2:0][31:0] d_dif_r;

  always_ff @(posedge clk) begin
    d_e_r <= d_e_nxt;
    d_dot_r <= d_dot_nxt;
    d_x_r <= d_x_nxt;
    d_zero_r <= c_zero_r;
    d_alb_r <= c_alb_r;
    d_dif_r <= c_dif_r;
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else begin
      d_valid_r <= c_valid_r;
    end
  end

  root_stage_t root_link [ROOT_CELLS+1];
  logic [33:0] r_ep;
  logic r_facing;

  always_comb begin
    r_ep = d_e_r[63:30];
    r_facing = !d_zero_r && !d_dot_r[49] && (d_dot_r != '0);
    root_link[0].ctx.valid = d_valid_r;
    root_link[0].ctx.zero = d_zero_r;
    root_link[0].ctx.facing = r_facing;
    root_link[0].ctx.cdvd = r_facing ? {d_dot_r[47:0], 2'b00} : '0;
    root_link[0].ctx.dif = d_dif_r;
    root_link[0].ctx.alb = d_alb_r;
    root_link[0].rt.rem = '0;
    root_link[0].rt.src = d_e_r;
    root_link[0].rt.root = '0;
    for (int i = 0; i < 3; i++) begin
      root_link[0].ctx.sat[i] = d_x_r[i][90:32] >= {25'd0, r_ep};
      root_link[0].il[i].rem = root_link[0].ctx.sat[i] ? '0 : {1'b0, d_x_r[i][65:32]};
      root_link[0].il[i].low = d_x_r[i][31:0];
      root_link[0].il[i].quo = '0;
      root_link[0].il[i].den = r_ep;
    end
  end

  for (genvar g = 0; g < ROOT_CELLS; g++) begin : g_root
    pls_root_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_in  (root_link[g]),
      .stage_out (root_link[g+1])
    );
  end

  cos_stage_t cos_link [COS_CELLS+1];
  root_stage_t r_end;

  always_comb begin
    r_end = root_link[ROOT_CELLS];
    cos_link[0].ctx.valid = r_end.ctx.valid;
    cos_link[0].ctx.zero = r_end.ctx.zero;
    cos_link[0].ctx.facing = r_end.ctx.facing;
    cos_link[0].ctx.dif = r_end.ctx.dif;
    cos_link[0].ctx.alb = r_end.ctx.alb;
    for (int i = 0; i < 3; i++) begin
      if (!r_end.ctx.facing) begin
        cos_link[0].ctx.il[i] = '0;
      end else if (r_end.ctx.sat[i]) begin
        cos_link[0].ctx.il[i] = MAX32;
      end else begin
        cos_link[0].ctx.il[i] = r_end.il[i].quo;
      end
    end
    cos_link[0].cd.rem = {5'd0, r_end.ctx.cdvd[49:20]};
    cos_link[0].cd.low = {r_end.ctx.cdvd[19:0], 12'd0};
    cos_link[0].cd.quo = '0;
    cos_link[0].cd.den = {2'b00, r_end.rt.root};
  end

  for (genvar g = 0; g < COS_CELLS; g++) begin : g_cos
    pls_cos_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_in  (cos_link[g]),
      .stage_out (cos_link[g+1])
    );
  end

  cos_stage_t k_end;
  logic [2:0][47:0] g_ia_nxt;

  always_comb begin
    k_end = cos_link[COS_CELLS];
    for (int i = 0; i < 3; i++) begin
      g_ia_nxt[i] = 48'(k_end.ctx.il[i]) * 48'(k_end.ctx.alb[i]);
    end
  end

  logic g_valid_r, g_zero_r, g_facing_r;
  logic [19:0] g_cos_r;
  logic [2:0][31:0] g_ia_r, g_il_r, g_dif_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      g_ia_r[i] <= g_ia_nxt[i][47:16];
    end
    g_cos_r <= k_end.cd.quo[19:0];
    g_il_r <= k_end.ctx.il;
    g_dif_r <= k_end.ctx.dif;
    g_zero_r <= k_end.ctx.zero;
    g_facing_r <= k_end.ctx.facing;
    if (!rst_n) begin
      g_valid_r <= 1'b0;
    end else begin
      g_valid_r <= k_end.ctx.valid;
    end
  end

  logic [2:0][51:0] h_m_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      h_m_nxt[i] = 52'(g_ia_r[i]) * 52'(g_cos_r);
    end
  end

  logic h_valid_r, h_zero_r, h_facing_r;
  logic [2:0][35:0] h_add_r;
  logic [2:0][31:0] h_il_r, h_dif_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      h_add_r[i] <= h_m_nxt[i][51:16];
    end
    h_il_r <= g_il_r;
    h_dif_r <= g_dif_r;
    h_zero_r <= g_zero_r;
    h_facing_r <= g_facing_r;
    if (!rst_n) begin
      h_valid_r <= 1'b0;
    end else begin
      h_valid_r <= g_valid_r;
    end
  end

  logic [2:0][36:0] o_sum;
  logic [2:0][31:0] o_dif;
  pls_out_t out_data_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      o_sum[i] = {5'd0, h_dif_r[i]} + {1'b0, h_add_r[i]};
      o_dif[i] = (o_sum[i][36:32] != '0) ? MAX32 : o_sum[i][31:0];
    end
    out_data_nxt.illum_red = h_il_r[0];
    out_data_nxt.illum_green = h_il_r[1];
    out_data_nxt.illum_blue = h_il_r[2];
    out_data_nxt.diffuse_out_red = o_dif[0];
    out_data_nxt.diffuse_out_green = o_dif[1];
    out_data_nxt.diffuse_out_blue = o_dif[2];
    out_data_nxt.facing = h_facing_r;
    out_data_nxt.zero_distance = h_zero_r;
  end

  pls_out_t out_data_r;
  logic out_valid_r;

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= h_valid_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

FILE: sv/pls_root_cell.sv
// One cell of the square root and illumination divide chain.
// Advances the root lane and three divide lanes by one bit; uses pls_pkg.
module pls_root_cell import pls_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  root_stage_t stage_in,
  output root_stage_t stage_out
);

  root_stage_t stage_nxt;
  root_stage_t stage_r;

  always_comb begin
    stage_nxt = stage_in;
    stage_nxt.rt = root_step(stage_in.rt);
    for (int i = 0; i < 3; i++) begin
      stage_nxt.il[i] = div_step(stage_in.il[i]);
    end
    if (!rst_n) begin
      stage_nxt.ctx.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
  end

  assign stage_out = stage_r;

endmodule

FILE: sv/pls_cos_cell.sv
// One cell of the cosine divide chain.
// Advances the cosine divide lane by one quotient bit; uses pls_pkg.
module pls_cos_cell import pls_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cos_stage_t stage_in,
  output cos_stage_t stage_out
);

  cos_stage_t stage_nxt;
  cos_stage_t stage_r;

  always_comb begin
    stage_nxt = stage_in;
    stage_nxt.cd = div_step(stage_in.cd);
    if (!rst_n) begin
      stage_nxt.ctx.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
  end

  assign stage_out = stage_r;

endmodule

FILE: sv/pls_checker.sv
// Port-level checker for point_light_lambert_shade, bound to the top level.
// Uses pls_pkg for the payload types and the pipeline latency.
module pls_checker import pls_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input pls_in_t     in_data,
  input logic        out_valid,
  input pls_out_t    out_data
);

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("transaction lost in pipeline");

  a_no_phantom: assert property (@(posedge clk)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without a transaction");

  a_zero_unlit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.zero_distance) |-> !out_data.facing)
    else $error("zero distance reported as facing");

  a_unlit_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.facing) |->
      (out_data.illum_red == '0) && (out_data.illum_green == '0)
      && (out_data.illum_blue == '0)
      && (out_data.diffuse_out_red == $past(in_data.diffuse_in_red, LATENCY))
      && (out_data.diffuse_out_green == $past(in_data.diffuse_in_green, LATENCY))
      && (out_data.diffuse_out_blue == $past(in_data.diffuse_in_blue, LATENCY)))
    else $error("unlit transaction changed diffuse sum");

endmodule

bind point_light_lambert_shade pls_checker u_pls_checker (.*);

FILE: bench/pls_shade_checker.sv
`timescale 1ns / 1ps
// Checker for point_light_lambert_shade: tracks light registers, predicts each shading
// result and compares it with the block output in order. Depends on pls_pkg.
module pls_shade_checker import pls_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_wdata,
  input  logic        start,
  input  logic        busy,
  input  pls_in_t     in_data,
  input  logic        out_valid,
  input  pls_out_t    out_data,
  output int          fail_count,
  output int          pending
);

  localparam logic [63:0] M32 = 64'hFFFF_FFFF;

  logic signed [31:0] lt_x, lt_y, lt_z;
  logic [15:0] lt_col [3];
  logic [31:0] lt_power;
  pls_out_t shade_q [$];

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] falloff_div(logic [63:0] p, logic [63:0] den, int t);
    logic [63:0] q, r;
    q = p / den;
    r = p % den;
    if (t < 0) begin
      q = (-t >= 64) ? 64'd0 : (q >> (-t));
    end else begin
      for (int i = 0; i < t && q <= M32; i++) begin
        q = q << 1;
        r = r << 1;
        if (r >= den) begin
          r = r - den;
          q = q + 1;
        end
      end
    end
    return (q > M32) ? M32 : q;
  endfunction

  function automatic pls_out_t shade(pls_in_t it);
    pls_out_t o;
    longint d [3];
    longint nv [3];
    longint dot;
    logic [63:0] mag [3];
    logic [63:0] dif [3];
    logic [63:0] alb [3];
    logic [63:0] il [3];
    logic [63:0] m, esum, root, ep, cosq, a, p, add, s;
    int sh;
    d[0] = longint'(lt_x) - longint'(it.hit_x);
    d[1] = longint'(lt_y) - longint'(it.hit_y);
    d[2] = longint'(lt_z) - longint'(it.hit_z);
    nv[0] = longint'(it.normal_x);
    nv[1] = longint'(it.normal_y);
    nv[2] = longint'(it.normal_z);
    alb[0] = it.albedo_red;
    alb[1] = it.albedo_green;
    alb[2] = it.albedo_blue;
    dif[0] = it.diffuse_in_red;
    dif[1] = it.diffuse_in_green;
    dif[2] = it.diffuse_in_blue;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (d[i] < 0) ? 64'(-d[i]) : 64'(d[i]);
      il[i] = 0;
    end
    m = mag[0];
    if (mag[1] > m) m = mag[1];
    if (mag[2] > m) m = mag[2];
    o = '0;
    o.zero_distance = (m == 0);
    if (m != 0) begin
      sh = 0;
      while (m < (64'd1 << 30)) begin
        m = m << 1;
        sh++;
      end
      if (m >= (64'd1 << 31)) sh = -1;
      esum = 0;
      dot = 0;
      for (int i = 0; i < 3; i++) begin
        a = (sh < 0) ? (mag[i] >> 1) : (mag[i] << sh);
        esum = esum + a * a;
        dot = dot + nv[i] * ((d[i] < 0) ? -longint'(a) : longint'(a));
      end
      if (dot > 0) begin
        o.facing = 1'b1;
        root = int_sqrt(esum);
        cosq = (64'(dot) << 2) / root;
        ep = esum >> 30;
        for (int i = 0; i < 3; i++) begin
          p = ((64'(lt_col[i]) * 64'(lt_power)) >> 16) * 64'(INV_4PI);
          il[i] = falloff_div(p, ep, 2 * sh - 30);
          add = (((il[i] * alb[i]) >> 16) * cosq) >> 16;
          s = dif[i] + add;
          dif[i] = (s > M32) ? M32 : s;
        end
      end
    end
    o.illum_red = il[0][31:0];
    o.illum_green = il[1][31:0];
    o.illum_blue = il[2][31:0];
    o.diffuse_out_red = dif[0][31:0];
    o.diffuse_out_green = dif[1][31:0];
    o.diffuse_out_blue = dif[2][31:0];
    return o;
  endfunction

  task automatic cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    pls_out_t ex;
    if (!rst_n) begin
      lt_x <= '0;
      lt_y <= '0;
      lt_z <= '0;
      lt_col[0] <= 16'hFFFF;
      lt_col[1] <= 16'hFFFF;
      lt_col[2] <= 16'hFFFF;
      lt_power <= 32'h0001_0000;
      shade_q.delete();
      pending <= 0;
    end else begin
      if (start && !busy) shade_q.push_back(shade(in_data));
      if (out_valid) begin
        if (shade_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none actual %h", $time, out_data);
        end else begin
          ex = shade_q.pop_front();
          cmp_field("illum_red", ex.illum_red, out_data.illum_red);
          cmp_field("illum_green", ex.illum_green, out_data.illum_green);
          cmp_field("illum_blue", ex.illum_blue, out_data.illum_blue);
          cmp_field("diffuse_out_red", ex.diffuse_out_red, out_data.diffuse_out_red);
          cmp_field("diffuse_out_green", ex.diffuse_out_green, out_data.diffuse_out_green);
          cmp_field("diffuse_out_blue", ex.diffuse_out_blue, out_data.diffuse_out_blue);
          cmp_field("facing", 32'(ex.facing), 32'(out_data.facing));
          cmp_field("zero_distance", 32'(ex.zero_distance), 32'(out_data.zero_distance));
        end
      end
      pending <= shade_q.size();
      if (cfg_we) begin
        case (cfg_idx)
          CFG_POS_X: lt_x <= cfg_wdata;
          CFG_POS_Y: lt_y <= cfg_wdata;
          CFG_POS_Z: lt_z <= cfg_wdata;
          CFG_RED:   lt_col[0] <= cfg_wdata[15:0];
          CFG_GREEN: lt_col[1] <= cfg_wdata[15:0];
          CFG_BLUE:  lt_col[2] <= cfg_wdata[15:0];
          CFG_POWER: lt_power <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: bench/point_light_lambert_shade_tb.sv
`timescale 1ns / 1ps
// Top of the point_light_lambert_shade testbench: clock, reset, light setup and
// hit point stimulus. Depends on pls_pkg, the block and pls_shade_checker.
module point_light_lambert_shade_tb;
  import pls_pkg::*;

  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam int WATCHDOG = 20000;
  localparam int PHASES = 6;
  localparam int PER_PHASE = 200;

  logic clk, rst_n, cfg_we, start, busy, out_valid;
  logic [2:0] cfg_idx;
  logic [31:0] cfg_wdata;
  pls_in_t in_data;
  pls_out_t out_data;
  int fail_count, pending, idle_cycles, n_sent, n_results, burst_left;
  logic signed [31:0] pos [3];

  point_light_lambert_shade u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy), .in_data(in_data), .out_valid(out_valid),
    .out_data(out_data)
  );

  pls_shade_checker u_chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy), .in_data(in_data), .out_valid(out_valid),
    .out_data(out_data), .fail_count(fail_count), .pending(pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (out_valid) n_results++;
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    if (idx == CFG_POS_X) pos[0] = val;
    if (idx == CFG_POS_Y) pos[1] = val;
    if (idx == CFG_POS_Z) pos[2] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send(pls_in_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    start <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_sent++;
  endtask

  function automatic pls_in_t rand_hit();
    pls_in_t it;
    logic [31:0] off;
    it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
          $urandom};
    if ($urandom_range(0, 9) < 8) begin
      off = $urandom;
      it.hit_x = pos[0] + (signed'(off) >>> $urandom_range(0, 31));
      off = $urandom;
      it.hit_y = pos[1] + (signed'(off) >>> $urandom_range(0, 31));
      off = $urandom;
      it.hit_z = pos[2] + (signed'(off) >>> $urandom_range(0, 31));
      if ($urandom_range(0, 2) != 0) begin
        it.normal_x = signed'(16'($urandom_range(0, 32768))) - 16'sd16384;
        it.normal_y = signed'(16'($urandom_range(0, 32768))) - 16'sd16384;
        it.normal_z = signed'(16'($urandom_range(0, 32768))) - 16'sd16384;
      end
      if ($urandom_range(0, 3) != 0) begin
        it.diffuse_in_red = it.diffuse_in_red >> $urandom_range(0, 31);
        it.diffuse_in_green = it.diffuse_in_green >> $urandom_range(0, 31);
        it.diffuse_in_blue = it.diffuse_in_blue >> $urandom_range(0, 31);
      end
    end
    return it;
  endfunction

  task automatic directed();
    pls_in_t it;
    it = '0;
    it.hit_x = pos[0];
    it.hit_y = pos[1];
    it.hit_z = pos[2];
    it.normal_z = 16'sh4000;
    it.albedo_red = 16'hFFFF;
    it.albedo_green = 16'hFFFF;
    it.albedo_blue = 16'hFFFF;
    it.diffuse_in_red = 32'h1234_5678;
    send(it);
    it.hit_z = pos[2] - 32'sd65536;
    send(it);
    it.normal_z = -16'sh4000;
    send(it);
    it.normal_z = 16'sh7FFF;
    it.normal_x = 16'sh7FFF;
    it.normal_y = 16'sh7FFF;
    it.diffuse_in_red = 32'hFFFF_FFFF;
    it.diffuse_in_green = 32'hFFFF_FFF0;
    send(it);
    it.hit_z = pos[2] - 32'sd1;
    send(it);
    it.normal_x = -16'sh8000;
    it.normal_y = -16'sh8000;
    it.normal_z = -16'sh8000;
    send(it);
    it.hit_x = 32'sh7FFF_FFFF;
    it.hit_y = -32'sh8000_0000;
    it.hit_z = -32'sh8000_0000;
    it.normal_x = -16'sh4000;
    it.normal_y = 16'sh4000;
    it.normal_z = 16'sh4000;
    it.albedo_red = '0;
    send(it);
    it.hit_x = -32'sh8000_0000;
    it.hit_y = 32'sh7FFF_FFFF;
    it.hit_z = 32'sh7FFF_FFFF;
    it.normal_x = 16'sh4000;
    it.normal_y = -16'sh4000;
    it.normal_z = -16'sh4000;
    send(it);
    it.hit_x = pos[0];
    it.hit_y = pos[1];
    it.hit_z = pos[2] + 32'sd3;
    it.normal_z = '0;
    it.normal_x = '0;
    it.normal_y = '0;
    send(it);
  endtask

  initial begin
    logic [31:0] v;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_POS_X;
    cfg_wdata = '0;
    start = 1'b0;
    in_data = '0;
    idle_cycles = 0;
    n_sent = 0;
    n_results = 0;
    burst_left = 0;
    pos[0] = 0;
    pos[1] = 0;
    pos[2] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        case (ph)
          1: begin
            write_reg(CFG_POS_X, 32'h7FFF_FFFF);
            write_reg(CFG_POS_Y, 32'h8000_0000);
            write_reg(CFG_POS_Z, 32'h7FFF_FFFF);
            write_reg(CFG_RED, 32'h0);
            write_reg(CFG_GREEN, 32'hFFFF);
            write_reg(CFG_BLUE, 32'h1);
            write_reg(CFG_POWER, 32'hFFFF_FFFF);
          end
          2: begin
            write_reg(CFG_POS_X, 32'h8000_0000);
            write_reg(CFG_POS_Y, 32'h7FFF_FFFF);
            write_reg(CFG_POS_Z, 32'h0);
            write_reg(CFG_POWER, 32'h0);
            write_reg(CFG_UNUSED, 32'h1234_5678);
          end
          default: begin
            write_reg(CFG_POS_X, $urandom);
            write_reg(CFG_POS_Y, $urandom);
            write_reg(CFG_POS_Z, $urandom);
            write_reg(CFG_RED, $urandom);
            write_reg(CFG_GREEN, $urandom);
            write_reg(CFG_BLUE, $urandom);
            v = $urandom >> $urandom_range(0, 31);
            write_reg(CFG_POWER, v);
          end
        endcase
      end
      directed();
      for (int i = 0; i < PER_PHASE; i++) send(rand_hit());
    end
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d hit points over %0d light settings, %0d results checked",
             n_sent, PHASES, n_results);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
